// ----- design/vdma_pkg.sv -----
// shared types and constants for the vram dma controller
// used by vdma_engine and vram_dma_controller; no dependencies
package vdma_pkg;

	// register indexes of a write item
	localparam logic [2:0] REG_SRC_HI = 3'd0;
	localparam logic [2:0] REG_SRC_LO = 3'd1;
	localparam logic [2:0] REG_DST_HI = 3'd2;
	localparam logic [2:0] REG_DST_LO = 3'd3;
	localparam logic [2:0] REG_CTRL   = 3'd4;

	// item kinds
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// lcd modes in which a general transfer is skipped
	localparam logic [1:0] LCD_MODE_OAM  = 2'd2;
	localparam logic [1:0] LCD_MODE_XFER = 2'd3;

	localparam logic [15:0] VRAM_BASE     = 16'h8000;
	localparam logic [7:0]  CTRL_LEN_MASK = 8'h7F;
	localparam logic [7:0]  CTRL_DONE     = 8'h80;
	localparam logic [7:0]  ADDR_LO_MASK  = 8'hF0;
	localparam logic [7:0]  DST_HI_MASK   = 8'h1F;
	localparam logic [11:0] HBLANK_BYTES  = 12'd16;

	typedef struct packed {
		logic       command;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [1:0] lcd_mode;
	} vdma_item_t;

	typedef struct packed {
		logic        copy_valid;
		logic [15:0] source_address;
		logic [15:0] dest_address;
		logic [11:0] byte_count;
		logic [7:0]  status_byte;
		logic        hblank_active;
	} vdma_result_t;

endpackage

// ----- design/vdma_engine.sv -----
// register file and transfer logic of the vram dma controller
// depends on vdma_pkg; steps once for each item when step is high
module vdma_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  vdma_pkg::vdma_item_t  item,
	output vdma_pkg::vdma_result_t result
);

	logic [7:0] src_hi_q, src_lo_q, dst_hi_q, dst_lo_q, ctrl_q, blocks_q;
	logic       engine_on_q;

	logic [7:0]  src_hi_d, src_lo_d, dst_hi_d, dst_lo_d, ctrl_d, blocks_d;
	logic        engine_on_d;
	logic [15:0] src_base, dst_base, offset, next_src, next_dst;
	logic [11:0] blk_diff, gen_len;
	logic [6:0]  data_len;

	assign src_base = {src_hi_q, src_lo_q & vdma_pkg::ADDR_LO_MASK};
	assign dst_base = {dst_hi_q & vdma_pkg::DST_HI_MASK, dst_lo_q & vdma_pkg::ADDR_LO_MASK};
	// block offset of the next hblank copy
	assign blk_diff = 12'({5'd0, ctrl_q[6:0]}) + 12'd1 - 12'(blocks_q);
	assign offset   = {blk_diff, 4'd0};
	assign data_len = item.write_data[6:0];
	// (n + 1) blocks of 16 bytes, at most 2048
	assign gen_len  = {({1'b0, data_len} + 8'd1), 4'd0};
	assign next_src = src_base + 16'(gen_len);
	assign next_dst = dst_base + 16'(gen_len);

	always_comb begin
		src_hi_d    = src_hi_q;
		src_lo_d    = src_lo_q;
		dst_hi_d    = dst_hi_q;
		dst_lo_d    = dst_lo_q;
		ctrl_d      = ctrl_q;
		blocks_d    = blocks_q;
		engine_on_d = engine_on_q;
		result      = '0;
		if (item.command == vdma_pkg::CMD_TICK) begin
			if (engine_on_q) begin
				if (blocks_q != 8'd0) begin
					result.copy_valid     = 1'b1;
					result.source_address = src_base + offset;
					result.dest_address   = vdma_pkg::VRAM_BASE + dst_base + offset;
					result.byte_count     = vdma_pkg::HBLANK_BYTES;
					blocks_d              = blocks_q - 8'd1;
				end else begin
					engine_on_d = 1'b0;
					ctrl_d      = ctrl_q | vdma_pkg::CTRL_DONE;
				end
			end
		end else begin
			case (item.reg_index)
				vdma_pkg::REG_SRC_HI: src_hi_d = item.write_data;
				vdma_pkg::REG_SRC_LO: src_lo_d = item.write_data;
				vdma_pkg::REG_DST_HI: dst_hi_d = item.write_data;
				vdma_pkg::REG_DST_LO: dst_lo_d = item.write_data;
				vdma_pkg::REG_CTRL: begin
					if (item.write_data[7]) begin
						// arm hblank mode
						blocks_d    = {1'b0, data_len} + 8'd1;
						ctrl_d      = item.write_data & vdma_pkg::CTRL_LEN_MASK;
						engine_on_d = 1'b1;
					end else begin
						if (!(item.lcd_mode inside {vdma_pkg::LCD_MODE_OAM,
								vdma_pkg::LCD_MODE_XFER})) begin
							src_hi_d              = next_src[15:8];
							src_lo_d              = next_src[7:0];
							dst_hi_d              = next_dst[15:8];
							dst_lo_d              = next_dst[7:0];
							result.copy_valid     = 1'b1;
							result.source_address = src_base;
							result.dest_address   = dst_base + vdma_pkg::VRAM_BASE;
							result.byte_count     = gen_len;
						end
						ctrl_d      = item.write_data | vdma_pkg::CTRL_DONE;
						engine_on_d = 1'b0;
					end
				end
				default: ;
			endcase
		end
		result.status_byte   = ctrl_d;
		result.hblank_active = engine_on_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_hi_q    <= '0;
			src_lo_q    <= '0;
			dst_hi_q    <= '0;
			dst_lo_q    <= '0;
			ctrl_q      <= '0;
			blocks_q    <= '0;
			engine_on_q <= 1'b0;
		end else if (step) begin
			src_hi_q    <= src_hi_d;
			src_lo_q    <= src_lo_d;
			dst_hi_q    <= dst_hi_d;
			dst_lo_q    <= dst_lo_d;
			ctrl_q      <= ctrl_d;
			blocks_q    <= blocks_d;
			engine_on_q <= engine_on_d;
		end
	end

endmodule

// ----- design/vram_dma_controller.sv -----
// top level of the vram dma controller: input register, engine, result register
// depends on vdma_pkg and vdma_engine
//
// vram dma controller with general and hblank transfers. each input word is either a
// register write (tuser 0) or an hblank tick (tuser 1) and yields exactly one result
// word, which describes at most one block copy (tuser 1 when a copy is requested).
// one word is taken every clock cycle in steady state while m_tready is high; a word
// moves from the input register into the result register, from which it is taken.
// the register file updates when a word leaves the input register, so words are
// handled strictly in order and a write takes effect for the very next word.
// s_tready follows m_tready through the result register: when the result register
// holds an untaken word, the input register still takes one more word.
module vram_dma_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // reg_index[2:0], write_data[10:3], lcd_mode[12:11], zeros
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // source_address[15:0], dest_address[31:16],
	                               // byte_count[43:32], status_byte[51:44],
	                               // hblank_active[52], zeros
	output logic        m_tuser    // copy_valid
);

	logic                   in_valid_s1;
	vdma_pkg::vdma_item_t   item_s1;
	logic                   out_valid_s2;
	vdma_pkg::vdma_result_t result_s2;
	vdma_pkg::vdma_result_t result_comb;
	logic                   advance;

	// the item in the input register moves on when the result register is free or being emptied
	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command    <= s_tuser;
			item_s1.reg_index  <= s_tdata[2:0];
			item_s1.write_data <= s_tdata[10:3];
			item_s1.lcd_mode   <= s_tdata[12:11];
		end
	end

	vdma_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_comb;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tuser  = result_s2.copy_valid;
	assign m_tdata  = {3'd0, result_s2.hblank_active, result_s2.status_byte,
		result_s2.byte_count, result_s2.dest_address, result_s2.source_address};

`ifndef NO_ASSERTIONS
	// a word without a copy carries no descriptor
	a_no_copy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[43:0] == 44'd0))
		else $error("descriptor fields set without a copy");

	// a copy while hblank stays armed is always one 16-byte block
	a_hblank_block: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser && m_tdata[52]) |-> (m_tdata[43:32] == vdma_pkg::HBLANK_BYTES))
		else $error("hblank copy with wrong byte count");

	// armed hblank reads back as busy, idle reads back done after a general copy
	a_busy_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[52]) |-> !m_tdata[51])
		else $error("status bit 7 set while hblank armed");

	a_general_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser && !m_tdata[52]) |-> m_tdata[51])
		else $error("general copy without done status");
`endif

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for vram_dma_controller: random and directed writes and hblank ticks
// depends on vdma_pkg and the design files; expected words come from a predictor in this file
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_TARGET  = 550;
	localparam int REPORT_LIMIT = 10;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [15:0] s_tdata  = '0;   // reg_index[2:0], write_data[10:3], lcd_mode[12:11], zeros
	logic        s_tuser  = 1'b0; // command
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [55:0] m_tdata;         // source_address[15:0], dest_address[31:16],
	                              // byte_count[43:32], status_byte[51:44], hblank_active[52]
	wire         m_tuser;         // copy_valid

	// predictor copy of the dma register file and hblank engine
	logic [7:0] src_hi_q = '0, src_lo_q = '0, dst_hi_q = '0, dst_lo_q = '0;
	logic [7:0] ctrl_q = '0, blocks_left_q = '0;
	logic       engine_on_q = 1'b0;

	// expected result words, oldest first
	vdma_pkg::vdma_result_t descriptor_q[$];

	int fault_count   = 0;
	int counted_words = 0;
	int quiet_left    = 0;
	int sink_left     = 0;
	logic sink_on     = 1'b0;

	vram_dma_controller u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advance the predicted register file by one word and return its result word
	function automatic vdma_pkg::vdma_result_t next_descriptor(input logic cmd,
			input logic [2:0] idx, input logic [7:0] data, input logic [1:0] mode);
		vdma_pkg::vdma_result_t r;
		logic [15:0] src_base, dst_base, offset, len, next_src, next_dst;
		r = '0;
		src_base = {src_hi_q, src_lo_q & vdma_pkg::ADDR_LO_MASK};
		dst_base = {dst_hi_q & vdma_pkg::DST_HI_MASK, dst_lo_q & vdma_pkg::ADDR_LO_MASK};
		if (cmd == vdma_pkg::CMD_TICK) begin
			if (engine_on_q && blocks_left_q != 8'd0) begin
				// block offset counts up from zero as blocks_left counts down
				offset = ({8'd0, ctrl_q & vdma_pkg::CTRL_LEN_MASK} + 16'd1
					- {8'd0, blocks_left_q}) << 4;
				r.copy_valid     = 1'b1;
				r.source_address = src_base + offset;
				r.dest_address   = vdma_pkg::VRAM_BASE + dst_base + offset;
				r.byte_count     = vdma_pkg::HBLANK_BYTES;
				blocks_left_q    = blocks_left_q - 8'd1;
			end else if (engine_on_q) begin
				// tick after the last block stops the engine
				engine_on_q = 1'b0;
				ctrl_q      = ctrl_q | vdma_pkg::CTRL_DONE;
			end
		end else begin
			case (idx)
				vdma_pkg::REG_SRC_HI: src_hi_q = data;
				vdma_pkg::REG_SRC_LO: src_lo_q = data;
				vdma_pkg::REG_DST_HI: dst_hi_q = data;
				vdma_pkg::REG_DST_LO: dst_lo_q = data;
				vdma_pkg::REG_CTRL: begin
					if ((data & vdma_pkg::CTRL_DONE) != 8'd0) begin
						// arm hblank mode, also when already armed
						blocks_left_q = (data & vdma_pkg::CTRL_LEN_MASK) + 8'd1;
						ctrl_q        = data & vdma_pkg::CTRL_LEN_MASK;
						engine_on_q   = 1'b1;
					end else begin
						ctrl_q = data;
						if (mode != vdma_pkg::LCD_MODE_OAM
								&& mode != vdma_pkg::LCD_MODE_XFER) begin
							len      = ({8'd0, data & vdma_pkg::CTRL_LEN_MASK} + 16'd1) << 4;
							next_src = src_base + len;
							next_dst = dst_base + len;
							src_hi_q = next_src[15:8];
							src_lo_q = next_src[7:0];
							// full high byte, not masked to the vram range
							dst_hi_q = next_dst[15:8];
							dst_lo_q = next_dst[7:0];
							r.copy_valid     = 1'b1;
							r.source_address = src_base;
							r.dest_address   = dst_base + vdma_pkg::VRAM_BASE;
							r.byte_count     = len[11:0];
						end
						ctrl_q      = ctrl_q | vdma_pkg::CTRL_DONE;
						engine_on_q = 1'b0;
					end
				end
				default: ;
			endcase
		end
		r.status_byte   = ctrl_q;
		r.hblank_active = engine_on_q;
		return r;
	endfunction

	// sender gap: mostly none, some short, a few long, and quiet stretches
	function automatic int pick_gap();
		int roll;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// extremes show up more often than a flat spread would give them
	function automatic logic [7:0] rand_byte();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 8'h00;
		if (roll == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// send one word; entered and left at a falling edge
	task automatic put_word(input logic cmd, input logic [2:0] idx, input logic [7:0] data,
			input logic [1:0] mode);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, mode, data, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		counted_words++;
		descriptor_q.push_back(next_descriptor(cmd, idx, data, mode));
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		put_word(vdma_pkg::CMD_WRITE, idx, data, 2'($urandom_range(0, 3)));
	endtask

	// tick with random filler in the unused fields
	task automatic tick();
		put_word(vdma_pkg::CMD_TICK, 3'($urandom_range(0, 7)), rand_byte(),
			2'($urandom_range(0, 3)));
	endtask

	// hold the sender off until every result word has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (descriptor_q.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic test_register_file();
		write_reg(vdma_pkg::REG_SRC_HI, 8'hFF);
		write_reg(vdma_pkg::REG_SRC_LO, 8'hFF);
		write_reg(vdma_pkg::REG_DST_HI, 8'hFF);
		write_reg(vdma_pkg::REG_DST_LO, 8'hFF);
		// unused indexes change nothing
		for (int i = 5; i < 8; i++) write_reg(i[2:0], rand_byte());
		// tick while the engine is idle
		tick();
	endtask

	task automatic test_general_transfer();
		// longest transfer from the top of the address space, advance wraps
		put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, 8'h7F, 2'd0);
		// shortest transfer from the wrapped addresses
		put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, 8'h00, 2'd1);
		// skipped during oam scan and pixel transfer, done bit still set
		put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, 8'h05, vdma_pkg::LCD_MODE_OAM);
		put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, 8'h05, vdma_pkg::LCD_MODE_XFER);
	endtask

	task automatic test_hblank_transfer();
		// arming is not gated by the lcd mode
		put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, 8'h81, vdma_pkg::LCD_MODE_XFER);
		tick();
		// address write between blocks moves the later blocks
		write_reg(vdma_pkg::REG_DST_LO, 8'h00);
		tick();
		// tick after the last block stops, then an idle tick
		tick();
		tick();
		// arm with one block, then a general transfer while armed
		put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, 8'h80, 2'd0);
		put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, 8'h01, 2'd0);
		// arm from idle, then re-arm while armed
		put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, 8'hFF, 2'd1);
		tick();
		put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, 8'h83, 2'd0);
		tick();
	endtask

	task automatic test_random();
		int roll, blocks, ticks;
		logic [2:0] pick;
		while (counted_words < WORD_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				// well-formed transfer: load some addresses, then a control write
				for (int k = 0; k < 4; k++)
					if ($urandom_range(0, 9) < 7) write_reg(k[2:0], rand_byte());
			end
			if (roll < 45) begin
				// hblank transfer, mostly few blocks
				if ($urandom_range(0, 29) == 0)
					blocks = $urandom_range(0, 127);
				else
					blocks = $urandom_range(0, 6);
				put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, {1'b1, blocks[6:0]},
					2'($urandom_range(0, 3)));
				ticks = blocks + 1 + int'($urandom_range(0, 2));
				repeat (ticks) begin
					roll = $urandom_range(0, 99);
					if (roll < 12) begin
						pick = 3'($urandom_range(0, 3));
						write_reg(pick, rand_byte());
					end else if (roll < 15) begin
						put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL, rand_byte(),
							2'($urandom_range(0, 3)));
					end
					tick();
				end
			end else if (roll < 75) begin
				put_word(vdma_pkg::CMD_WRITE, vdma_pkg::REG_CTRL,
					{1'b0, 7'($urandom_range(0, 127))}, 2'($urandom_range(0, 3)));
			end else begin
				// noise: any kind, any index
				repeat ($urandom_range(1, 4))
					put_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), rand_byte(),
						2'($urandom_range(0, 3)));
			end
			if ($urandom_range(0, 29) == 0) wait_for_results();
		end
	endtask

	// compare one result word with the oldest expectation
	task automatic check_word();
		vdma_pkg::vdma_result_t got, want;
		got = '0;
		got.copy_valid     = m_tuser;
		got.source_address = m_tdata[15:0];
		got.dest_address   = m_tdata[31:16];
		got.byte_count     = m_tdata[43:32];
		got.status_byte    = m_tdata[51:44];
		got.hblank_active  = m_tdata[52];
		if (descriptor_q.size() == 0) begin
			fault_count++;
			if (fault_count <= REPORT_LIMIT)
				$display("%0t: result word with nothing expected", $realtime);
		end else begin
			want = descriptor_q.pop_front();
			if (got !== want) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT) begin
					$display("%0t: expected copy %0d src %h dst %h count %0d status %h hblank %0d",
						$realtime, want.copy_valid, want.source_address, want.dest_address,
						want.byte_count, want.status_byte, want.hblank_active);
					$display("    got      copy %0d src %h dst %h count %0d status %h hblank %0d",
						got.copy_valid, got.source_address, got.dest_address,
						got.byte_count, got.status_byte, got.hblank_active);
				end
			end
		end
	endtask

	// result side sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_word();
	end

	// receiver stalls: alternating ready and stall runs, some long ready and stall runs
	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_on = !sink_on;
			if (sink_on)
				sink_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 8);
			else
				sink_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
					: $urandom_range(1, 3);
		end
		sink_left--;
		m_tready <= sink_on;
	end

	initial begin
		// reset held low at the start, then released at a falling edge
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_register_file();
		test_general_transfer();
		test_hblank_transfer();
		wait_for_results();
		test_random();
		wait_for_results();
		// two-stage pipe, then wait on to catch stray words
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
